### rtl/potential_field_steering_macros.svh
// Assertion helpers, clocked on i_clk and off while i_rst_n is low.
`ifndef POTENTIAL_FIELD_STEERING_MACROS_SVH
`define POTENTIAL_FIELD_STEERING_MACROS_SVH

`define PFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pfs_pkg.sv
`default_nettype none
package pfs_pkg;
    localparam int MAX_RAYS   = 1024;
    localparam int RAY_W      = $clog2(MAX_RAYS);
    localparam int TRIG_BITS  = 16;
    localparam int TRIG_SHIFT = 30 - TRIG_BITS;
    localparam int TRIG_W     = TRIG_BITS + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [15:0] BAM_QUARTER = 16'h4000;
    localparam logic [15:0] BAM_HALF    = 16'h8000;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_REP  = 2'd1;
    localparam logic [1:0] CLS_ATT  = 2'd2;

    localparam logic [2:0] CFG_THR_LO    = 3'd0;
    localparam logic [2:0] CFG_THR_HI    = 3'd1;
    localparam logic [2:0] CFG_REP_OFF   = 3'd2;
    localparam logic [2:0] CFG_REP_SLOPE = 3'd3;
    localparam logic [2:0] CFG_ATT_SLOPE = 3'd4;
    localparam logic [2:0] CFG_SCANS     = 3'd5;
    localparam logic [2:0] CFG_ANG_START = 3'd6;
    localparam logic [2:0] CFG_ANG_STEP  = 3'd7;

    localparam logic signed [31:0] SIN_SEED  = -32'sd3864;
    localparam logic signed [31:0] ATAN_SEED = 32'sd7823447;

    typedef struct packed {
        logic [15:0] range_reading;
        logic        reading_valid;
        logic        last_ray;
    } t_in;

    typedef struct packed {
        logic [14:0]        steer_cdeg;
        logic signed [15:0] bearing_cdeg;
    } t_out;

    typedef struct packed {
        logic [15:0] threshold_low;
        logic [15:0] threshold_high;
        logic [15:0] repulsive_offset;
        logic [15:0] repulsive_slope;
        logic [15:0] attractive_slope;
        logic [7:0]  scans_per_result;
        logic [15:0] angle_start;
        logic [15:0] angle_step;
    } t_cfg;

    typedef struct packed {
        logic [15:0] range;
        logic [1:0]  cls;
        logic [15:0] ang;
        logic        last;
    } t_ray;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic signed [31:0] sin_coef(input logic [3:0] k);
        logic signed [31:0] c;
        unique case (k)
            4'd0:    c = 32'sd172272;
            4'd1:    c = -32'sd5026994;
            4'd2:    c = 32'sd85569306;
            4'd3:    c = -32'sd693598669;
            default: c = 32'sd1686629713;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] atan_coef(input logic [3:0] k);
        logic signed [31:0] c;
        unique case (k)
            4'd0:    c = -32'sd31966898;
            4'd1:    c = 32'sd67641796;
            4'd2:    c = -32'sd124025355;
            default: c = 32'sd375443304;
        endcase
        return c;
    endfunction

    // arithmetic shift right, rounding toward zero
    function automatic logic signed [67:0] trunc_shr(input logic signed [67:0] v,
                                                     input int unsigned sh);
        logic signed [67:0] bias;
        bias = v[67] ? ((68'sd1 <<< sh) - 68'sd1) : 68'sd0;
        return (v + bias) >>> sh;
    endfunction
endpackage
`default_nettype wire

### rtl/pfs_front.sv
`default_nettype none
module pfs_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pfs_pkg::t_cfg  i_cfg,
    input  wire logic           i_push,
    input  wire pfs_pkg::t_in   i_in,
    input  wire pfs_pkg::t_qstat i_qstat,
    output logic                o_q_push,
    output pfs_pkg::t_ray       o_ray,
    output logic                o_full
);
    logic [pfs_pkg::RAY_W-1:0]    r_ray_idx;
    logic [pfs_pkg::RAY_W+15:0]   ang_prod;
    logic                         accept;

    assign accept   = i_push && !i_qstat.full;
    assign o_full   = i_qstat.full;
    assign o_q_push = accept;
    assign ang_prod = i_cfg.angle_step * r_ray_idx;

    always_comb begin
        o_ray.range = i_in.range_reading;
        o_ray.last  = i_in.last_ray;
        o_ray.ang   = i_cfg.angle_start + ang_prod[15:0];
        if (!i_in.reading_valid) begin
            o_ray.cls = pfs_pkg::CLS_NONE;
        end else if (i_in.range_reading < i_cfg.threshold_low) begin
            o_ray.cls = pfs_pkg::CLS_REP;
        end else if (i_in.range_reading > i_cfg.threshold_high) begin
            o_ray.cls = pfs_pkg::CLS_ATT;
        end else begin
            o_ray.cls = pfs_pkg::CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_idx <= '0;
        end else if (accept) begin
            if (i_in.last_ray) begin
                r_ray_idx <= '0;
            end else if (r_ray_idx != pfs_pkg::RAY_W'(pfs_pkg::MAX_RAYS - 1)) begin
                r_ray_idx <= r_ray_idx + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/pfs_queue.sv
`default_nettype none
module pfs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pfs_pkg::t_ray  i_ray,
    input  wire logic           i_pop,
    output pfs_pkg::t_ray       o_ray,
    output pfs_pkg::t_qstat     o_stat
);
    pfs_pkg::t_ray                  r_mem [pfs_pkg::QDEPTH];
    logic [pfs_pkg::QPTR_W-1:0]     r_wr;
    logic [pfs_pkg::QPTR_W-1:0]     r_rd;
    logic [pfs_pkg::QCNT_W-1:0]     r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_stat.full  = (r_cnt == pfs_pkg::QCNT_W'(pfs_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_ray        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/pfs_back.sv
`default_nettype none
`include "potential_field_steering_macros.svh"
module pfs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pfs_pkg::t_cfg  i_cfg,
    input  wire pfs_pkg::t_ray  i_ray,
    input  wire pfs_pkg::t_qstat i_qstat,
    output logic                o_q_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output pfs_pkg::t_out       o_out
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_WMUL = 5'd1;
    localparam logic [4:0] S_WFIX = 5'd2;
    localparam logic [4:0] S_TZ   = 5'd3;
    localparam logic [4:0] S_TZR  = 5'd4;
    localparam logic [4:0] S_TM   = 5'd5;
    localparam logic [4:0] S_TA   = 5'd6;
    localparam logic [4:0] S_TF   = 5'd7;
    localparam logic [4:0] S_TR   = 5'd8;
    localparam logic [4:0] S_TC   = 5'd9;
    localparam logic [4:0] S_TS   = 5'd10;
    localparam logic [4:0] S_CHK  = 5'd11;
    localparam logic [4:0] S_AMAG = 5'd12;
    localparam logic [4:0] S_ANRM = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_AT2  = 5'd15;
    localparam logic [4:0] S_AT2R = 5'd16;
    localparam logic [4:0] S_AM   = 5'd17;
    localparam logic [4:0] S_AA   = 5'd18;
    localparam logic [4:0] S_AF   = 5'd19;
    localparam logic [4:0] S_AR   = 5'd20;
    localparam logic [4:0] S_EMIT = 5'd21;

    localparam logic [pfs_pkg::TRIG_W-1:0] TRIG_ONE =
        pfs_pkg::TRIG_W'(1 << pfs_pkg::TRIG_BITS);

    logic [4:0]                     r_state;
    pfs_pkg::t_ray                  r_ray;
    logic [32:0]                    r_mag;
    logic [15:0]                    r_a;
    logic                           r_phase;
    logic [30:0]                    r_z2;
    logic signed [31:0]             r_p;
    logic [3:0]                     r_k;
    logic [pfs_pkg::TRIG_W-1:0]     r_trig;
    logic signed [67:0]             r_prod;
    logic signed [63:0]             r_sum_x;
    logic signed [63:0]             r_sum_y;
    logic [7:0]                     r_scan;
    logic [63:0]                    r_mx;
    logic [63:0]                    r_mn;
    logic [47:0]                    r_rem;
    logic [16:0]                    r_q;
    logic [16:0]                    r_t2;
    logic                           r_xneg;
    logic                           r_yneg;
    logic                           r_ygtx;
    logic signed [15:0]             r_raw;
    logic                           r_out_valid;
    pfs_pkg::t_out                  r_out;

    logic signed [33:0]             mul_a;
    logic signed [33:0]             mul_b;
    logic [14:0]                    trig_x;
    logic signed [33:0]             w_val;
    logic signed [67:0]             pf;
    logic [30:0]                    pc;
    logic [31:0]                    pr;
    logic signed [63:0]             contrib;
    logic [63:0]                    ax;
    logic [63:0]                    ay;
    logic [47:0]                    rs;
    logic                           ge;
    logic [63:0]                    vr;
    logic [13:0]                    a_u;
    logic [13:0]                    a_c;
    logic [14:0]                    m1;
    logic [14:0]                    m2;
    logic [7:0]                     scan_nx;
    logic                           out_free;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    assign o_q_pop  = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_empty  = !r_out_valid;
    assign o_out    = r_out;
    assign out_free = !r_out_valid || i_pop;
    assign scan_nx  = r_scan + 1'b1;

    assign trig_x = r_a[14] ? 15'(17'd16384 - {3'b0, r_a[13:0]}) : {1'b0, r_a[13:0]};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_WMUL: begin
                mul_a = 34'(r_ray.range);
                mul_b = (r_ray.cls == pfs_pkg::CLS_REP) ? 34'(i_cfg.repulsive_slope)
                                                         : 34'(i_cfg.attractive_slope);
            end
            S_TZ: begin
                mul_a = 34'(trig_x);
                mul_b = 34'(trig_x);
            end
            S_TM: begin
                mul_a = 34'(r_p);
                mul_b = 34'(r_z2);
            end
            S_TF: begin
                mul_a = 34'(r_p);
                mul_b = 34'(trig_x);
            end
            S_TC: begin
                mul_a = 34'(r_mag);
                mul_b = 34'(r_trig);
            end
            S_AT2: begin
                mul_a = 34'(r_q);
                mul_b = 34'(r_q);
            end
            S_AM: begin
                mul_a = 34'(r_p);
                mul_b = 34'(r_t2);
            end
            S_AF: begin
                mul_a = 34'(r_p);
                mul_b = 34'(r_q);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_val = $signed(r_prod[33:0]) -
                ((r_ray.cls == pfs_pkg::CLS_REP) ? $signed({10'b0, i_cfg.repulsive_offset, 8'b0})
                                                 : 34'sd0);
        pf = pfs_pkg::trunc_shr(r_prod, 14);
        if (pf < 68'sd0) begin
            pc = '0;
        end else if (pf > 68'sd1073741824) begin
            pc = 31'd1073741824;
        end else begin
            pc = pf[30:0];
        end
        pr = (32'(pc) + 32'(1 << (pfs_pkg::TRIG_SHIFT - 1))) >> pfs_pkg::TRIG_SHIFT;
        contrib = r_a[15] ? -$signed(r_prod[63:0]) : $signed(r_prod[63:0]);
        ax = r_sum_x[63] ? (64'd0 - r_sum_x) : r_sum_x;
        ay = r_sum_y[63] ? (64'd0 - r_sum_y) : r_sum_y;
        rs = {r_rem[46:0], 1'b0};
        ge = (rs >= {1'b0, r_mx[46:0]});
        vr = r_prod[67] ? 64'd0 : (r_prod[63:0] + 64'h8000_0000);
        a_u = (vr[63:46] != '0) ? 14'd16383 : vr[45:32];
        a_c = (a_u > 14'd4500) ? 14'd4500 : a_u;
        m1 = r_ygtx ? (15'd9000 - 15'(a_c)) : 15'(a_c);
        m2 = r_xneg ? (15'd18000 - m1) : m1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_scan      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_ray   <= i_ray;
                        r_state <= (i_ray.cls == pfs_pkg::CLS_NONE) ? S_CHK : S_WMUL;
                    end
                end
                S_WMUL: r_state <= S_WFIX;
                S_WFIX: begin
                    r_mag     <= w_val[33] ? 33'(-w_val) : w_val[32:0];
                    r_ray.ang <= w_val[33] ? (r_ray.ang + pfs_pkg::BAM_HALF) : r_ray.ang;
                    r_a       <= (w_val[33] ? (r_ray.ang + pfs_pkg::BAM_HALF) : r_ray.ang)
                                 + pfs_pkg::BAM_QUARTER;
                    r_phase   <= 1'b0;
                    r_state   <= S_TZ;
                end
                S_TZ: r_state <= S_TZR;
                S_TZR: begin
                    r_z2    <= {r_prod[28:0], 2'b0};
                    r_p     <= pfs_pkg::SIN_SEED;
                    r_k     <= '0;
                    r_state <= S_TM;
                end
                S_TM: r_state <= S_TA;
                S_TA: begin
                    r_p <= pfs_pkg::sin_coef(r_k) + 32'(pfs_pkg::trunc_shr(r_prod, 30));
                    if (r_k == 4'd4) begin
                        r_state <= S_TF;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_TM;
                    end
                end
                S_TF: r_state <= S_TR;
                S_TR: begin
                    r_trig  <= pfs_pkg::TRIG_W'(pr);
                    r_state <= S_TC;
                end
                S_TC: r_state <= S_TS;
                S_TS: begin
                    if (!r_phase) begin
                        r_sum_x <= sat_add(r_sum_x, contrib);
                        r_phase <= 1'b1;
                        r_a     <= r_ray.ang;
                        r_state <= S_TZ;
                    end else begin
                        r_sum_y <= sat_add(r_sum_y, contrib);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!r_ray.last) begin
                        r_state <= S_IDLE;
                    end else if (scan_nx < i_cfg.scans_per_result) begin
                        r_scan  <= scan_nx;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_AMAG;
                    end
                end
                S_AMAG: begin
                    r_mx   <= (ax > ay) ? ax : ay;
                    r_mn   <= (ax > ay) ? ay : ax;
                    r_xneg <= r_sum_x[63];
                    r_yneg <= r_sum_y[63];
                    r_ygtx <= (ay > ax);
                    if (ax == '0 && ay == '0) begin
                        r_raw   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_ANRM;
                    end
                end
                S_ANRM: begin
                    if (r_mx[63:47] != '0) begin
                        r_mx <= r_mx >> 1;
                        r_mn <= r_mn >> 1;
                    end else begin
                        r_q     <= {(r_mn >= r_mx), 16'b0};
                        r_rem   <= (r_mn >= r_mx) ? (r_mn[47:0] - r_mx[47:0]) : r_mn[47:0];
                        r_k     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? (rs - {1'b0, r_mx[46:0]}) : rs;
                    r_q   <= {r_q[16], r_q[14:0], ge};
                    r_k   <= r_k + 1'b1;
                    if (r_k == 4'd15) begin
                        r_state <= S_AT2;
                    end
                end
                S_AT2: r_state <= S_AT2R;
                S_AT2R: begin
                    r_t2    <= r_prod[32:16];
                    r_p     <= pfs_pkg::ATAN_SEED;
                    r_k     <= '0;
                    r_state <= S_AM;
                end
                S_AM: r_state <= S_AA;
                S_AA: begin
                    r_p <= pfs_pkg::atan_coef(r_k) + 32'(pfs_pkg::trunc_shr(r_prod, 16));
                    if (r_k == 4'd3) begin
                        r_state <= S_AF;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_AM;
                    end
                end
                S_AF: r_state <= S_AR;
                S_AR: begin
                    r_raw   <= r_yneg ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.bearing_cdeg <= r_raw;
                        if (r_raw <= -16'sd9000) begin
                            r_out.steer_cdeg <= 15'd18000;
                        end else if (r_raw <= 16'sd0) begin
                            r_out.steer_cdeg <= '0;
                        end else begin
                            r_out.steer_cdeg <= r_raw[14:0];
                        end
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_scan  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PFS_ASSERT_NXT(a_emit_loads, (r_state == S_EMIT) && out_free, r_out_valid && (r_state == S_IDLE), "result not loaded")
    `PFS_ASSERT_IMP(a_steer_range, r_out_valid, r_out.steer_cdeg <= 15'd18000, "steering out of range")
    `PFS_ASSERT_IMP(a_trig_bound, r_state == S_TC, r_trig <= TRIG_ONE, "trig above unity")
    `PFS_ASSERT_NXT(a_pop_dispatch, o_q_pop, (r_state == S_WMUL) || (r_state == S_CHK), "bad dispatch")
endmodule
`default_nettype wire

### rtl/potential_field_steering.sv
// Potential-field steering from a laser scan.
// Input queue: drive i_in_data and push while full is low; one request per ray
// (range, valid flag, last-ray mark). Rays are indexed in arrival order within a scan.
// Result queue: while empty is low o_out_data holds the oldest steering result;
// pop takes it. One result follows the last ray of every scans_per_result-th scan.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr; write only idle.
// Work per ray is done by the single shared 34x34 multiplier in the back end:
// a ray with no weight goes straight to the last-ray check; a weighted ray takes two
// Horner sine evaluations and two saturating accumulations. A result adds
// normalization (up to 17 shifts), a 16-step divide and an atan polynomial.
// A two-entry queue decouples ray intake from the back end; the result sits in
// an output register, so a stalled receiver only stops the back end at the
// moment the next result is ready, and intake continues until the queue fills.
// Synchronous active-low reset clears counters, sums, queues and registers
// to their defaults; no clearing pass is needed.
`default_nettype none
module potential_field_steering (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire pfs_pkg::t_in i_in_data,
    input  wire logic       pop,
    output logic            empty,
    output pfs_pkg::t_out   o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);
    pfs_pkg::t_cfg      r_cfg;
    pfs_pkg::t_ray      front_ray;
    pfs_pkg::t_ray      q_ray;
    pfs_pkg::t_qstat    q_stat;
    logic               q_push;
    logic               q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_low    <= 16'd2560;
            r_cfg.threshold_high   <= 16'd2560;
            r_cfg.repulsive_offset <= 16'd12800;
            r_cfg.repulsive_slope  <= '0;
            r_cfg.attractive_slope <= '0;
            r_cfg.scans_per_result <= 8'd2;
            r_cfg.angle_start      <= '0;
            r_cfg.angle_step       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pfs_pkg::CFG_THR_LO:    r_cfg.threshold_low    <= i_cfg_wdata;
                pfs_pkg::CFG_THR_HI:    r_cfg.threshold_high   <= i_cfg_wdata;
                pfs_pkg::CFG_REP_OFF:   r_cfg.repulsive_offset <= i_cfg_wdata;
                pfs_pkg::CFG_REP_SLOPE: r_cfg.repulsive_slope  <= i_cfg_wdata;
                pfs_pkg::CFG_ATT_SLOPE: r_cfg.attractive_slope <= i_cfg_wdata;
                pfs_pkg::CFG_SCANS:     r_cfg.scans_per_result <= i_cfg_wdata[7:0];
                pfs_pkg::CFG_ANG_START: r_cfg.angle_start      <= i_cfg_wdata;
                pfs_pkg::CFG_ANG_STEP:  r_cfg.angle_step       <= i_cfg_wdata;
                default:                r_cfg.angle_step       <= r_cfg.angle_step;
            endcase
        end
    end

    pfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (push),
        .i_in    (i_in_data),
        .i_qstat (q_stat),
        .o_q_push(q_push),
        .o_ray   (front_ray),
        .o_full  (full)
    );

    pfs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_ray  (front_ray),
        .i_pop  (q_pop),
        .o_ray  (q_ray),
        .o_stat (q_stat)
    );

    pfs_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_ray  (q_ray),
        .i_qstat(q_stat),
        .o_q_pop(q_pop),
        .i_pop  (pop),
        .o_empty(empty),
        .o_out  (o_out_data)
    );
endmodule
`default_nettype wire
